// ----- hdl/ucs_pkg.sv -----
// ucs_pkg: types and constants shared by the uct child selector
// no dependencies; imported by ucs_front, ucs_back and uct_child_selector
package ucs_pkg;

   localparam int COUNT_BITS   = 20;
   localparam int FRAC_BITS    = 16;
   localparam int SCORE_BITS   = FRAC_BITS + 4;
   localparam int POS_BITS     = 8;
   localparam int DIST_BITS    = POS_BITS + 1;
   localparam int INDEX_BITS   = 8;
   localparam int MANT_BITS    = 30;
   localparam int MSB_BITS     = 5;
   localparam int LOG_BITS     = MSB_BITS + FRAC_BITS;
   localparam int LN_BITS      = LOG_BITS;
   localparam int DIV_BITS     = LN_BITS + 1 + FRAC_BITS;
   localparam int SQRT_STEPS   = DIV_BITS / 2;
   localparam int STEP_BITS    = 6;
   localparam int ADDR_BITS    = 4;
   localparam int DATA_BITS    = 32;

   localparam logic [31:0]           LN2_Q32   = 32'd2977044472;
   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

   localparam logic [1:0] REG_PARENT_VISITS = 2'd0;
   localparam logic [1:0] REG_PARENT_X      = 2'd1;
   localparam logic [1:0] REG_PARENT_Y      = 2'd2;

   typedef struct packed {
      logic [COUNT_BITS-1:0] child_wins;
      logic [COUNT_BITS-1:0] child_visits;
      logic [POS_BITS-1:0]   child_x;
      logic [POS_BITS-1:0]   child_y;
      logic                  last_child;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] best_index;
      logic [SCORE_BITS-1:0] best_score;
      logic [DIST_BITS-1:0]  best_distance;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] wins;
      logic [COUNT_BITS-1:0] visits;
      logic                  unvisited;
      logic [DIST_BITS-1:0]  distance;
      logic                  last;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG,
      ST_LN,
      ST_DIV,
      ST_SQRT,
      ST_SUM,
      ST_PICK
   } back_state_type;

endpackage

// ----- hdl/ucs_front.sv -----
// ucs_front: accepts child words, works out distance and the unvisited flag
// and holds them in a two-entry queue; uses ucs_pkg
module ucs_front
   import ucs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   input  logic [POS_BITS-1:0] parent_x,
   input  logic [POS_BITS-1:0] parent_y,
   output logic                job_valid,
   output job_type             job,
   input  logic                job_pop
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   job_type     classified;
   logic [POS_BITS-1:0] dx, dy;

   always_comb begin
      dx = (req_data.child_x > parent_x) ? req_data.child_x - parent_x
                                         : parent_x - req_data.child_x;
      dy = (req_data.child_y > parent_y) ? req_data.child_y - parent_y
                                         : parent_y - req_data.child_y;
      classified.wins      = req_data.child_wins;
      classified.visits    = req_data.child_visits;
      classified.unvisited = (req_data.child_visits == '0);
      classified.distance  = {1'b0, dx} + {1'b0, dy};
      classified.last      = req_data.last_child;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !job_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("accepted word not queued");

endmodule

// ----- hdl/ucs_back.sv -----
// ucs_back: iterative uct score (log2, ln, dividers, root), running best
// and result register; uses ucs_pkg
module ucs_back
   import ucs_pkg::*;
#(
   parameter int MAX_CHILDREN = 256,
   parameter int CNT_BITS     = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  job_pop,
   input  logic [COUNT_BITS-1:0] parent_visits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   back_state_type state_ff, state_in;
   job_type  job_ff, job_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [MSB_BITS-1:0]   msb_ff, msb_in;
   logic [MANT_BITS:0]    m_ff, m_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [DIV_BITS-1:0]   dq_ff, dq_in, eq_ff, eq_in;
   logic [COUNT_BITS-1:0] dr_ff, dr_in, er_ff, er_in;
   logic [DIV_BITS-1:0]   sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic                  have_best_ff, have_best_in;
   logic [SCORE_BITS-1:0] run_score_ff, run_score_in;
   logic [DIST_BITS-1:0]  run_dist_ff, run_dist_in;
   logic [CNT_BITS-1:0]   run_idx_ff, run_idx_in, cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS-1:0]   p_eff;
   logic [MSB_BITS-1:0]     p_msb;
   logic [2*MANT_BITS+1:0]  sq;
   logic [MANT_BITS+1:0]    sq_top;
   logic [LOG_BITS+31:0]    ln_prod;
   logic [COUNT_BITS:0]     dr_try, er_try;
   logic                    dr_ge, er_ge;
   logic [DIV_BITS-1:0]     s_try;
   logic [DIV_BITS:0]       sum;
   logic                    better, take, can_finish;
   logic [CNT_BITS+INDEX_BITS-1:0] idx_ext;
   logic [CNT_BITS-1:0]     idx_pick;

   always_comb begin
      p_eff = (parent_visits == '0) ? COUNT_BITS'(1) : parent_visits;
      p_msb = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (p_eff[i]) p_msb = MSB_BITS'(i);
      end
   end

   always_comb begin
      sq      = m_ff * m_ff;
      sq_top  = sq[2*MANT_BITS+1:MANT_BITS];
      ln_prod = {msb_ff, frac_ff} * LN2_Q32;
      dr_try  = {dr_ff, dq_ff[DIV_BITS-1]};
      er_try  = {er_ff, eq_ff[DIV_BITS-1]};
      dr_ge   = dr_try >= {1'b0, job_ff.visits};
      er_ge   = er_try >= {1'b0, job_ff.visits};
      s_try   = sres_ff + sbit_ff;
      sum     = {1'b0, eq_ff} + {{(DIV_BITS-SQRT_STEPS+1){1'b0}}, sres_ff[SQRT_STEPS-1:0]};
      better  = !have_best_ff || (score_ff > run_score_ff) ||
                ((score_ff == run_score_ff) && (job_ff.distance < run_dist_ff));
      can_finish = !job_ff.last || !rsp_valid_ff || !rsp_stall;
      take       = (state_ff == ST_PICK) && can_finish;
      idx_pick   = better ? cnt_ff : run_idx_ff;
      idx_ext    = {{INDEX_BITS{1'b0}}, idx_pick};
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      msb_in       = msb_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      eq_in        = eq_ff;
      er_in        = er_ff;
      sx_in        = sx_ff;
      sres_in      = sres_ff;
      sbit_in      = sbit_ff;
      score_in     = score_ff;
      have_best_in = have_best_ff;
      run_score_in = run_score_ff;
      run_dist_in  = run_dist_ff;
      run_idx_in   = run_idx_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               msb_in   = p_msb;
               m_in     = (MANT_BITS+1)'({{(MANT_BITS+1-COUNT_BITS){1'b0}}, p_eff}
                          << (MSB_BITS'(MANT_BITS) - p_msb));
               frac_in  = '0;
               step_in  = '0;
               score_in = SCORE_MAX;
               state_in = job.unvisited ? ST_PICK : ST_LOG;
            end
         end
         ST_LOG: begin
            // square the mantissa, renormalise into [1,2)
            if (sq_top[MANT_BITS+1]) begin
               m_in    = sq_top[MANT_BITS+1:1];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = sq_top[MANT_BITS:0];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(FRAC_BITS - 1)) state_in = ST_LN;
         end
         ST_LN: begin
            dq_in   = {ln_prod[LOG_BITS+31:32], 1'b0, {FRAC_BITS{1'b0}}};
            eq_in   = {{(DIV_BITS-COUNT_BITS-FRAC_BITS){1'b0}}, job_ff.wins,
                       {FRAC_BITS{1'b0}}};
            dr_in   = '0;
            er_in   = '0;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit of each divider per cycle
            dq_in = {dq_ff[DIV_BITS-2:0], dr_ge};
            eq_in = {eq_ff[DIV_BITS-2:0], er_ge};
            dr_in = dr_ge ? COUNT_BITS'(dr_try - {1'b0, job_ff.visits})
                          : dr_try[COUNT_BITS-1:0];
            er_in = er_ge ? COUNT_BITS'(er_try - {1'b0, job_ff.visits})
                          : er_try[COUNT_BITS-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_BITS - 1)) begin
               sx_in    = dq_in;
               sres_in  = '0;
               sbit_in  = DIV_BITS'(1) << (2*SQRT_STEPS - 2);
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sx_ff >= s_try) begin
               sx_in   = sx_ff - s_try;
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(SQRT_STEPS - 1)) state_in = ST_SUM;
         end
         ST_SUM: begin
            score_in = (sum > {{(DIV_BITS+1-SCORE_BITS){1'b0}}, SCORE_MAX}) ? SCORE_MAX
                                                         : sum[SCORE_BITS-1:0];
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (can_finish) begin
               if (better) begin
                  have_best_in = 1'b1;
                  run_score_in = score_ff;
                  run_dist_in  = job_ff.distance;
                  run_idx_in   = cnt_ff;
               end
               cnt_in = (cnt_ff == CNT_BITS'(MAX_CHILDREN - 1)) ? '0 : cnt_ff + 1'b1;
               if (job_ff.last) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.best_index    = idx_ext[INDEX_BITS-1:0];
                  rsp_data_in.best_score    = better ? score_ff : run_score_ff;
                  rsp_data_in.best_distance = better ? job_ff.distance : run_dist_ff;
                  have_best_in = 1'b0;
                  run_score_in = '0;
                  run_dist_in  = '0;
                  run_idx_in   = '0;
                  cnt_in       = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_best_ff <= 1'b0;
         run_score_ff <= '0;
         run_dist_ff  <= '0;
         run_idx_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_best_ff <= have_best_in;
         run_score_ff <= run_score_in;
         run_dist_ff  <= run_dist_in;
         run_idx_ff   <= run_idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      step_ff     <= step_in;
      msb_ff      <= msb_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      dq_ff       <= dq_in;
      dr_ff       <= dr_in;
      eq_ff       <= eq_in;
      er_ff       <= er_in;
      sx_ff       <= sx_in;
      sres_ff     <= sres_in;
      sbit_ff     <= sbit_in;
      score_ff    <= score_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pick_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && !can_finish) |=> state_ff == ST_PICK)
      else $error("pick left while result register blocked");

   a_rsp_from_pick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PICK && $past(job_ff.last))
      else $error("result raised outside a last pick");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (take && job_ff.last) |=> !have_best_ff && cnt_ff == '0)
      else $error("run state not cleared after last child");

endmodule

// ----- hdl/uct_child_selector.sv -----
// uct_child_selector: top level, register port and the front/back split
// depends on ucs_pkg, ucs_front and ucs_back
//
// Usage: children stream in on req_valid/req_stall as req_data words
// (wins, visits, position, last flag). Each word is scored as UCT1 in
// unsigned Q4.16 and compared with the running best; the word flagged
// last_child produces one rsp_data word (index, score, distance) on
// rsp_valid/rsp_stall and the run restarts from index 0.
// A visited child passes through 16 log2 squarings on one multiplier, a
// ln multiply, the bit-serial dividers and the root, then sum and pick;
// an unvisited child goes straight to pick. The front queue holds two
// children, so the sender is stalled only once two wait behind the one in
// work. Registers parent_visits (0), parent_x (1), parent_y (2) sit at
// byte addresses 0, 4, 8 and are written while the block is idle; the
// user is bound to this, the block itself does not enforce it. Reset
// (synchronous) empties the queue, clears the run and sets parent_visits
// to 1. A stalled result holds its register and the back end waits at the
// pick of the next last child until it is taken.
module uct_child_selector
   import ucs_pkg::*;
#(
   parameter int MAX_CHILDREN = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   localparam int CNT_BITS = $clog2(MAX_CHILDREN);

   logic [COUNT_BITS-1:0] parent_visits_ff, parent_visits_in;
   logic [POS_BITS-1:0]   parent_x_ff, parent_x_in, parent_y_ff, parent_y_in;
   logic                  wr_en;
   logic                  job_valid, job_pop;
   job_type               job;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      parent_visits_in = parent_visits_ff;
      parent_x_in      = parent_x_ff;
      parent_y_in      = parent_y_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_PARENT_VISITS: parent_visits_in = pwdata[COUNT_BITS-1:0];
            REG_PARENT_X:      parent_x_in      = pwdata[POS_BITS-1:0];
            REG_PARENT_Y:      parent_y_in      = pwdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_PARENT_VISITS: prdata = {{(DATA_BITS-COUNT_BITS){1'b0}}, parent_visits_ff};
         REG_PARENT_X:      prdata = {{(DATA_BITS-POS_BITS){1'b0}}, parent_x_ff};
         REG_PARENT_Y:      prdata = {{(DATA_BITS-POS_BITS){1'b0}}, parent_y_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parent_visits_ff <= COUNT_BITS'(1);
         parent_x_ff      <= '0;
         parent_y_ff      <= '0;
      end else begin
         parent_visits_ff <= parent_visits_in;
         parent_x_ff      <= parent_x_in;
         parent_y_ff      <= parent_y_in;
      end
   end

   ucs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .parent_x  (parent_x_ff),
      .parent_y  (parent_y_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   ucs_back #(
      .MAX_CHILDREN (MAX_CHILDREN),
      .CNT_BITS     (CNT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .parent_visits (parent_visits_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule
